[hdl/acs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types and constants for the auto contrast stretch unit.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int CmdW   = 2;
  localparam int ByteW  = 8;
  localparam int GainW  = 14;
  localparam int ShiftQ = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_MEASURE = 2'd0,
    CMD_GAIN    = 2'd1,
    CMD_STRETCH = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam logic [GainW-1:0] GainNum  = 14'd10608;
  localparam logic [GainW-1:0] UnitGain = 14'd32;
  localparam logic [ByteW-1:0] MinReset = 8'd255;
  localparam logic [ByteW-1:0] MaxReset = 8'd0;
  localparam logic [ByteW-1:0] Range100 = 8'd100;
  localparam logic [ByteW-1:0] Range200 = 8'd200;
  localparam logic [ByteW-1:0] ByteMax  = 8'd255;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;
  localparam int DivCntW    = 4;
  localparam logic [DivCntW-1:0] DivLast = 4'(GainW - 1);

  typedef struct packed {
    cmd_t             cmd;
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

[hdl/acs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_in_if / acs_out_if
// Pixel command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface acs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

interface acs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  found_min;
  logic [7:0]  found_max;
  logic [13:0] gain_q5;
  logic        flat;

  modport source (output valid, out_red, out_green, out_blue, found_min, found_max,
                  gain_q5, flat, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, found_min, found_max,
                  gain_q5, flat, output ready);
endinterface

[hdl/acs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_front
// Accepts command transactions, drops unused commands, queues the rest.
// ----------------------------------------------------------------------------
module acs_front (
  input  logic                clk,
  input  logic                rst,
  acs_in_if.sink              pix_in,
  output acs_pkg::queue_head_t head,
  input  logic                pop
);

  acs_pkg::item_t                   mem [acs_pkg::QueueDepth];
  logic [acs_pkg::QueuePtrW-1:0]    wr_ptr;
  logic [acs_pkg::QueuePtrW-1:0]    rd_ptr;
  logic [acs_pkg::QueueCntW-1:0]    count;
  logic                             push;
  logic                             do_pop;
  acs_pkg::item_t                   in_item;

  assign in_item.cmd   = acs_pkg::cmd_t'(pix_in.cmd);
  assign in_item.red   = pix_in.in_red;
  assign in_item.green = pix_in.in_green;
  assign in_item.blue  = pix_in.in_blue;

  assign pix_in.ready = (count != acs_pkg::QueueCntW'(acs_pkg::QueueDepth));
  assign push   = pix_in.valid && pix_in.ready && (in_item.cmd != acs_pkg::CMD_NONE);
  assign do_pop = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/acs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_back
// Executes queued commands: min/max measure, serial gain divide, stretch.
// ----------------------------------------------------------------------------
module acs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  acs_pkg::queue_head_t head,
  output logic                 pop,
  acs_out_if.source            pix_out
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STRETCH,
    S_DIVIDE,
    S_GAIN_OUT
  } state_t;

  localparam int ProdW = acs_pkg::ByteW + acs_pkg::GainW;

  state_t                        state;
  logic [acs_pkg::ByteW-1:0]     measured_min;
  logic [acs_pkg::ByteW-1:0]     measured_max;
  logic [acs_pkg::GainW-1:0]     gain;
  logic [acs_pkg::ByteW-1:0]     black_level;

  logic [acs_pkg::ByteW-1:0]     black_pend;
  logic                          flat_pend;
  logic [acs_pkg::ByteW-1:0]     divisor;
  logic [acs_pkg::ByteW-1:0]     rem;
  logic [acs_pkg::GainW-1:0]     dividend;
  logic [acs_pkg::GainW-1:0]     quot;
  logic [acs_pkg::DivCntW-1:0]   bit_cnt;
  logic [ProdW-1:0]              prod_r;
  logic [ProdW-1:0]              prod_g;
  logic [ProdW-1:0]              prod_b;

  logic                          out_free;
  logic                          load_out;
  logic [acs_pkg::ByteW-1:0]     min_next;
  logic [acs_pkg::ByteW-1:0]     max_next;
  logic [acs_pkg::ByteW:0]       range_s;
  logic [acs_pkg::ByteW-1:0]     range_abs;
  logic [acs_pkg::ByteW-1:0]     adj;
  logic [acs_pkg::ByteW:0]       rem_trial;
  logic                          rem_ge;
  logic [acs_pkg::ByteW-1:0]     st_r;
  logic [acs_pkg::ByteW-1:0]     st_g;
  logic [acs_pkg::ByteW-1:0]     st_b;

  function automatic logic [acs_pkg::ByteW-1:0] byte_min3(
    input logic [acs_pkg::ByteW-1:0] a, b, c, d);
    logic [acs_pkg::ByteW-1:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    if (d < m) m = d;
    return m;
  endfunction

  function automatic logic [acs_pkg::ByteW-1:0] byte_max3(
    input logic [acs_pkg::ByteW-1:0] a, b, c, d);
    logic [acs_pkg::ByteW-1:0] m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    if (d > m) m = d;
    return m;
  endfunction

  function automatic logic [ProdW-1:0] chan_prod(
    input logic [acs_pkg::ByteW-1:0] c,
    input logic [acs_pkg::ByteW-1:0] blk,
    input logic [acs_pkg::GainW-1:0] g);
    logic [acs_pkg::ByteW-1:0] diff;
    diff = (c > blk) ? (c - blk) : '0;
    return ProdW'(diff) * ProdW'(g);
  endfunction

  function automatic logic [acs_pkg::ByteW-1:0] chan_clamp(input logic [ProdW-1:0] p);
    logic [ProdW-acs_pkg::ShiftQ-1:0] s;
    s = p[ProdW-1:acs_pkg::ShiftQ];
    return (|s[ProdW-acs_pkg::ShiftQ-1:acs_pkg::ByteW]) ? acs_pkg::ByteMax
                                                        : s[acs_pkg::ByteW-1:0];
  endfunction

  assign out_free = !pix_out.valid || pix_out.ready;
  assign load_out = ((state == S_STRETCH) || (state == S_GAIN_OUT)) && out_free;
  assign pop      = (state == S_IDLE) && head.valid;

  assign min_next = byte_min3(measured_min, head.item.red, head.item.green, head.item.blue);
  assign max_next = byte_max3(measured_max, head.item.red, head.item.green, head.item.blue);

  assign range_s   = {1'b0, measured_max} - {1'b0, measured_min};
  assign range_abs = range_s[acs_pkg::ByteW] ? (measured_min - measured_max)
                                             : range_s[acs_pkg::ByteW-1:0];
  assign adj = (range_abs >= acs_pkg::Range200) ? 8'd2 :
               (range_abs >= acs_pkg::Range100) ? 8'd1 : 8'd0;

  assign rem_trial = {rem, dividend[acs_pkg::GainW-1]};
  assign rem_ge    = (rem_trial >= {1'b0, divisor});

  assign st_r = chan_clamp(prod_r);
  assign st_g = chan_clamp(prod_g);
  assign st_b = chan_clamp(prod_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      measured_min  <= acs_pkg::MinReset;
      measured_max  <= acs_pkg::MaxReset;
      gain          <= acs_pkg::UnitGain;
      black_level   <= '0;
      pix_out.valid <= 1'b0;
    end else begin
      if (load_out) begin
        pix_out.valid <= 1'b1;
      end else if (pix_out.valid && pix_out.ready) begin
        pix_out.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            unique case (head.item.cmd)
              acs_pkg::CMD_MEASURE: begin
                measured_min <= min_next;
                measured_max <= max_next;
              end
              acs_pkg::CMD_GAIN: begin
                black_pend <= range_s[acs_pkg::ByteW] ? (measured_min - adj)
                                                      : (measured_min + adj);
                divisor    <= range_s[acs_pkg::ByteW-1:0];
                rem        <= '0;
                dividend   <= acs_pkg::GainNum;
                bit_cnt    <= '0;
                if (range_s[acs_pkg::ByteW] || (range_s == '0)) begin
                  flat_pend <= 1'b1;
                  quot      <= acs_pkg::GainNum;
                  state     <= S_GAIN_OUT;
                end else begin
                  flat_pend <= 1'b0;
                  state     <= S_DIVIDE;
                end
              end
              acs_pkg::CMD_STRETCH: begin
                prod_r <= chan_prod(head.item.red, black_level, gain);
                prod_g <= chan_prod(head.item.green, black_level, gain);
                prod_b <= chan_prod(head.item.blue, black_level, gain);
                state  <= S_STRETCH;
              end
              default: begin
              end
            endcase
          end
        end
        S_STRETCH: begin
          if (out_free) begin
            pix_out.out_red   <= st_r;
            pix_out.out_green <= st_g;
            pix_out.out_blue  <= st_b;
            pix_out.found_min <= '0;
            pix_out.found_max <= '0;
            pix_out.gain_q5   <= '0;
            pix_out.flat      <= 1'b0;
            state             <= S_IDLE;
          end
        end
        S_DIVIDE: begin
          rem      <= rem_ge ? acs_pkg::ByteW'(rem_trial - {1'b0, divisor})
                             : rem_trial[acs_pkg::ByteW-1:0];
          quot     <= {quot[acs_pkg::GainW-2:0], rem_ge};
          dividend <= {dividend[acs_pkg::GainW-2:0], 1'b0};
          bit_cnt  <= bit_cnt + 1'b1;
          if (bit_cnt == acs_pkg::DivLast) begin
            state <= S_GAIN_OUT;
          end
        end
        S_GAIN_OUT: begin
          if (out_free) begin
            pix_out.out_red   <= '0;
            pix_out.out_green <= '0;
            pix_out.out_blue  <= '0;
            pix_out.found_min <= measured_min;
            pix_out.found_max <= measured_max;
            pix_out.gain_q5   <= quot;
            pix_out.flat      <= flat_pend;
            gain              <= quot;
            black_level       <= black_pend;
            measured_min      <= acs_pkg::MinReset;
            measured_max      <= acs_pkg::MaxReset;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/auto_contrast_stretch_unit.sv]
`timescale 1ns / 1ps
// Measure updates the levels when popped; stretch goes through product and
//   output registers; gain runs a 14-step serial divider, skipped when flat.
// Throughput: measure 1 item/cycle; stretch/gain block new items until loaded.
// Reset (rst, synchronous): queue empty, min 255, max 0, gain 32, black level 0.
// Two-entry input queue decouples the command channel from execution.
// ----------------------------------------------------------------------------
// auto_contrast_stretch_unit
// Min/max contrast stretch of RGB pixels with Q5 gain computation.
// ----------------------------------------------------------------------------
module auto_contrast_stretch_unit (
  input  logic       clk,
  input  logic       rst,
  acs_in_if.sink     pix_in,
  acs_out_if.source  pix_out
);

  acs_pkg::queue_head_t head;
  logic                 pop;

  acs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pix_in),
    .head   (head),
    .pop    (pop)
  );

  acs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .pix_out (pix_out)
  );

endmodule

[bench/tb_auto_contrast_stretch_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_auto_contrast_stretch_unit
// Self-checking bench for the contrast stretch unit. A table of directed
// pixels covers reset state, empty and flat ranges, full-scale ranges and
// clamping. Random frames of measure, gain and stretch transactions follow,
// with noise commands and random stalls on both channels. Every result is
// checked field by field, against the row's value for typed rows, else
// against an in-bench model of the level tracking and gain arithmetic.
// ----------------------------------------------------------------------------
module tb_auto_contrast_stretch_unit;

  localparam int TotalItems = 1400;
  localparam int QuietAfter = 1250;
  localparam int HoldAt     = 500;
  localparam int HoldCycles = 80;
  localparam int PauseAt    = 900;
  localparam int CycleLimit = 300000;
  localparam int PrintCap   = 40;
  localparam int NumRows    = 25;

  typedef struct packed {
    logic [acs_pkg::ByteW-1:0] red;
    logic [acs_pkg::ByteW-1:0] green;
    logic [acs_pkg::ByteW-1:0] blue;
    logic [acs_pkg::ByteW-1:0] lo;
    logic [acs_pkg::ByteW-1:0] hi;
    logic [acs_pkg::GainW-1:0] gain;
    logic                      flat;
  } acs_result_t;

  typedef struct {
    acs_pkg::cmd_t             cmd;
    logic [acs_pkg::ByteW-1:0] r;
    logic [acs_pkg::ByteW-1:0] g;
    logic [acs_pkg::ByteW-1:0] b;
    bit                        typed;
    acs_result_t               want;
  } pixel_row_t;

  logic clk;
  logic rst;

  acs_in_if  in_ch ();
  acs_out_if out_ch ();

  auto_contrast_stretch_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (in_ch),
    .pix_out (out_ch)
  );

  // Levels and gain as the block should hold them
  logic [acs_pkg::ByteW-1:0] lvl_min;
  logic [acs_pkg::ByteW-1:0] lvl_max;
  logic [acs_pkg::GainW-1:0] cur_gain;
  logic [acs_pkg::ByteW-1:0] cur_black;

  acs_result_t pending_results [$];

  int  errors       = 0;
  int  results_seen = 0;
  int  items_sent   = 0;
  int  n_measure    = 0;
  int  n_gain       = 0;
  int  n_flat       = 0;
  int  n_stretch    = 0;
  int  n_clipped    = 0;
  int  cycle_cnt    = 0;
  bit  quiet        = 1'b0;
  bit  hold_req     = 1'b0;

  pixel_row_t pixel_rows [NumRows] = '{
    '{acs_pkg::CMD_STRETCH, 8'd0,   8'd128, 8'd255, 1'b1,
      '{8'd0, 8'd128, 8'd255, 8'd0, 8'd0, 14'd0, 1'b0}},
    '{acs_pkg::CMD_STRETCH, 8'd1,   8'd254, 8'd127, 1'b0, '0},
    '{acs_pkg::CMD_GAIN,    8'd0,   8'd0,   8'd0,   1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 14'd10608, 1'b1}},
    '{acs_pkg::CMD_STRETCH, 8'd255, 8'd254, 8'd253, 1'b1,
      '{8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 14'd0, 1'b0}},
    '{acs_pkg::CMD_NONE,    8'd255, 8'd255, 8'd255, 1'b1, '0},
    '{acs_pkg::CMD_MEASURE, 8'd0,   8'd255, 8'd128, 1'b0, '0},
    '{acs_pkg::CMD_NONE,    8'd0,   8'd0,   8'd0,   1'b1, '0},
    '{acs_pkg::CMD_GAIN,    8'd85,  8'd170, 8'd51,  1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 14'd41, 1'b0}},
    '{acs_pkg::CMD_STRETCH, 8'd255, 8'd2,   8'd3,   1'b1,
      '{8'd255, 8'd0, 8'd1, 8'd0, 8'd0, 14'd0, 1'b0}},
    '{acs_pkg::CMD_STRETCH, 8'd10,  8'd100, 8'd50,  1'b0, '0},
    '{acs_pkg::CMD_MEASURE, 8'd77,  8'd77,  8'd77,  1'b0, '0},
    '{acs_pkg::CMD_GAIN,    8'd0,   8'd0,   8'd0,   1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd77, 8'd77, 14'd10608, 1'b1}},
    '{acs_pkg::CMD_STRETCH, 8'd76,  8'd77,  8'd78,  1'b1,
      '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 14'd0, 1'b0}},
    '{acs_pkg::CMD_MEASURE, 8'd100, 8'd101, 8'd100, 1'b0, '0},
    '{acs_pkg::CMD_GAIN,    8'd0,   8'd0,   8'd0,   1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd100, 8'd101, 14'd10608, 1'b0}},
    '{acs_pkg::CMD_STRETCH, 8'd100, 8'd101, 8'd255, 1'b0, '0},
    '{acs_pkg::CMD_MEASURE, 8'd10,  8'd110, 8'd60,  1'b0, '0},
    '{acs_pkg::CMD_GAIN,    8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{acs_pkg::CMD_STRETCH, 8'd11,  8'd12,  8'd255, 1'b0, '0},
    '{acs_pkg::CMD_MEASURE, 8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{acs_pkg::CMD_STRETCH, 8'd170, 8'd85,  8'd42,  1'b0, '0},
    '{acs_pkg::CMD_MEASURE, 8'd200, 8'd200, 8'd200, 1'b0, '0},
    '{acs_pkg::CMD_GAIN,    8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{acs_pkg::CMD_MEASURE, 8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{acs_pkg::CMD_GAIN,    8'd0,   8'd0,   8'd0,   1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 14'd10608, 1'b1}}
  };

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               pending_results.size());
      $display("auto_contrast_stretch_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [acs_pkg::ByteW-1:0] stretch_byte(
    input logic [acs_pkg::ByteW-1:0] c);
    int diff;
    int prod;
    diff = int'(c) - int'(cur_black);
    if (diff <= 0) return '0;
    prod = (diff * int'(cur_gain)) >>> acs_pkg::ShiftQ;
    if (prod > int'(acs_pkg::ByteMax)) begin
      n_clipped++;
      return acs_pkg::ByteMax;
    end
    return prod[acs_pkg::ByteW-1:0];
  endfunction

  function automatic bit stretch_or_measure(input acs_pkg::cmd_t c,
                                            input logic [acs_pkg::ByteW-1:0] r,
                                            input logic [acs_pkg::ByteW-1:0] g,
                                            input logic [acs_pkg::ByteW-1:0] b,
                                            output acs_result_t res);
    logic [acs_pkg::ByteW-1:0] px [3];
    int span;
    res = '0;
    px  = '{r, g, b};
    case (c)
      acs_pkg::CMD_MEASURE: begin
        n_measure++;
        foreach (px[i]) begin
          if (px[i] < lvl_min) lvl_min = px[i];
          if (px[i] > lvl_max) lvl_max = px[i];
        end
        return 1'b0;
      end
      acs_pkg::CMD_GAIN: begin
        n_gain++;
        span   = int'(lvl_max) - int'(lvl_min);
        res.lo = lvl_min;
        res.hi = lvl_max;
        if (span > 0) begin
          cur_gain = acs_pkg::GainW'(int'(acs_pkg::GainNum) / span);
        end else begin
          cur_gain = acs_pkg::GainNum;
          res.flat = 1'b1;
          n_flat++;
        end
        // int division truncates toward zero, also for an empty range
        cur_black = acs_pkg::ByteW'(int'(lvl_min) + span / int'(acs_pkg::Range100));
        res.gain  = cur_gain;
        lvl_min   = acs_pkg::MinReset;
        lvl_max   = acs_pkg::MaxReset;
        return 1'b1;
      end
      acs_pkg::CMD_STRETCH: begin
        n_stretch++;
        res.red   = stretch_byte(r);
        res.green = stretch_byte(g);
        res.blue  = stretch_byte(b);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    if (errors <= PrintCap)
      $display("%0t result %0d: %s got %0d expected %0d", $time, results_seen, field,
               got, want);
  endtask

  task automatic compare_result(input acs_result_t got, input acs_result_t want);
    if (got.red !== want.red)
      report_mismatch("out_red", int'(got.red), int'(want.red));
    if (got.green !== want.green)
      report_mismatch("out_green", int'(got.green), int'(want.green));
    if (got.blue !== want.blue)
      report_mismatch("out_blue", int'(got.blue), int'(want.blue));
    if (got.lo !== want.lo)
      report_mismatch("found_min", int'(got.lo), int'(want.lo));
    if (got.hi !== want.hi)
      report_mismatch("found_max", int'(got.hi), int'(want.hi));
    if (got.gain !== want.gain)
      report_mismatch("gain_q5", int'(got.gain), int'(want.gain));
    if (got.flat !== want.flat)
      report_mismatch("flat", int'(got.flat), int'(want.flat));
  endtask

  always @(posedge clk) begin : result_check
    acs_result_t got;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.found_min,
              out_ch.found_max, out_ch.gain_q5, out_ch.flat};
      results_seen++;
      if (pending_results.size() == 0)
        report_mismatch("result with nothing pending", 1, 0);
      else
        compare_result(got, pending_results.pop_front());
    end
  end

  // Result channel: short random stalls, plus one long hold on request
  initial begin : result_sink
    int stall_left;
    int hold_left;
    bit hold_taken;
    stall_left   = 0;
    hold_left    = 0;
    hold_taken   = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldCycles;
      end
      if (rst) begin
        out_ch.ready = 1'b0;
      end else if (hold_left != 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        stall_left   = $urandom_range(0, 2);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_pixel(input acs_pkg::cmd_t c, input logic [acs_pkg::ByteW-1:0] r,
                            input logic [acs_pkg::ByteW-1:0] g,
                            input logic [acs_pkg::ByteW-1:0] b,
                            input bit typed, input acs_result_t typed_res);
    acs_result_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.cmd      = c;
    in_ch.in_red   = r;
    in_ch.in_green = g;
    in_ch.in_blue  = b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (stretch_or_measure(c, r, g, b, res))
      pending_results.push_back(typed ? typed_res : res);
    if (c != acs_pkg::CMD_NONE) items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [acs_pkg::ByteW-1:0] near_byte(input int base, input int spread);
    int v;
    v = base + $urandom_range(0, spread);
    if (v < 0) v = 0;
    if (v > int'(acs_pkg::ByteMax)) v = int'(acs_pkg::ByteMax);
    return acs_pkg::ByteW'(v);
  endfunction

  function automatic logic [acs_pkg::ByteW-1:0] rand_byte();
    return acs_pkg::ByteW'($urandom_range(0, 255));
  endfunction

  task automatic send_noise();
    send_pixel(acs_pkg::CMD_NONE, rand_byte(), rand_byte(), rand_byte(), 1'b0, '0);
  endtask

  task automatic send_random_stretch();
    int base;
    if ($urandom_range(0, 1) == 0)
      send_pixel(acs_pkg::CMD_STRETCH, rand_byte(), rand_byte(), rand_byte(), 1'b0, '0);
    else begin
      base = int'(cur_black) - 3;
      send_pixel(acs_pkg::CMD_STRETCH, near_byte(base, 10), near_byte(base, 10),
                 near_byte(base, 40), 1'b0, '0);
    end
  endtask

  // One frame: measure pass, gain, then stretched pixels, with some noise
  task automatic send_frame();
    int n_meas;
    int n_str;
    int spread;
    int base;
    n_meas = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
    case ($urandom_range(0, 3))
      0:       spread = $urandom_range(0, 3);
      1:       spread = $urandom_range(4, 60);
      default: spread = 255;
    endcase
    base = (spread == 255) ? 0 : $urandom_range(0, 255);
    repeat (n_meas) begin
      if ($urandom_range(0, 24) == 0) send_noise();
      if ($urandom_range(0, 19) == 0)
        send_random_stretch();
      else
        send_pixel(acs_pkg::CMD_MEASURE, near_byte(base, spread), near_byte(base, spread),
                   near_byte(base, spread), 1'b0, '0);
    end
    send_pixel(acs_pkg::CMD_GAIN, rand_byte(), rand_byte(), rand_byte(), 1'b0, '0);
    n_str = $urandom_range(1, 12);
    repeat (n_str) begin
      if ($urandom_range(0, 24) == 0) send_noise();
      send_random_stretch();
    end
  endtask

  initial begin : stimulus
    bit hold_done;
    bit pause_done;
    hold_done      = 1'b0;
    pause_done     = 1'b0;
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = acs_pkg::CMD_NONE;
    in_ch.in_red   = '0;
    in_ch.in_green = '0;
    in_ch.in_blue  = '0;
    lvl_min        = acs_pkg::MinReset;
    lvl_max        = acs_pkg::MaxReset;
    cur_gain       = acs_pkg::UnitGain;
    cur_black      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (pixel_rows[i])
      send_pixel(pixel_rows[i].cmd, pixel_rows[i].r, pixel_rows[i].g, pixel_rows[i].b,
                 pixel_rows[i].typed, pixel_rows[i].want);
    wait_results_drained();

    while (items_sent < TotalItems) begin
      if (!hold_done && items_sent >= HoldAt) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
        repeat (24) send_random_stretch();
      end
      if (!pause_done && items_sent >= PauseAt) begin
        pause_done = 1'b1;
        wait_results_drained();
      end
      if (items_sent >= QuietAfter) quiet = 1'b1;
      send_frame();
    end

    wait_results_drained();
    repeat (30) @(negedge clk);

    $display("ran %0d transactions: %0d measure, %0d gain (%0d flat), %0d stretch",
             items_sent, n_measure, n_gain, n_flat, n_stretch);
    $display("checked %0d results, %0d clamped channels, %0d field errors",
             results_seen, n_clipped, errors);
    if (errors == 0) begin
      $display("auto_contrast_stretch_unit: match");
    end else begin
      $display("auto_contrast_stretch_unit: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
hdl/acs_pkg.sv
hdl/acs_if.sv
hdl/acs_front.sv
hdl/acs_back.sv
hdl/auto_contrast_stretch_unit.sv
bench/tb_auto_contrast_stretch_unit.sv
